@@ design/tpp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types, constants and a helper function of the triangle projection
// block.
// ----------------------------------------------------------------------------
package tpp_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CAM_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_COS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_SIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_W   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_H   = 3'd7;

    localparam logic [1:0] VTX_FIRST  = 2'd0;
    localparam logic [1:0] VTX_SECOND = 2'd1;
    localparam logic [1:0] VTX_LAST   = 2'd2;

    localparam logic [7:0] CHR_W = "W";
    localparam logic [7:0] CHR_G = "G";
    localparam logic [7:0] CHR_R = "R";
    localparam logic [7:0] CHR_B = "B";
    localparam logic [7:0] CHR_M = "M";
    localparam logic [7:0] CHR_Y = "Y";
    localparam logic [7:0] CHR_C = "C";

    typedef struct packed {
        logic signed [31:0] v1_x;
        logic signed [31:0] v1_y;
        logic signed [31:0] v1_z;
        logic signed [31:0] v2_x;
        logic signed [31:0] v2_y;
        logic signed [31:0] v2_z;
        logic signed [31:0] v3_x;
        logic signed [31:0] v3_y;
        logic signed [31:0] v3_z;
        logic [7:0]         color_code;
    } t_tri_in;

    typedef struct packed {
        logic signed [31:0] p1_px;
        logic signed [31:0] p1_py;
        logic signed [31:0] p2_px;
        logic signed [31:0] p2_py;
        logic signed [31:0] p3_px;
        logic signed [31:0] p3_py;
        logic               visible;
        logic [23:0]        rgb_color;
        logic signed [31:0] mean_depth;
    } t_tri_out;

    // One vertex entering the projection pipeline.
    typedef struct packed {
        logic [1:0]         idx;
        logic signed [32:0] vx;
        logic signed [32:0] vy;
        logic signed [32:0] vz;
        logic signed [34:0] dsum;
        logic [23:0]        rgb;
    } t_vtx_in;

    // One projected vertex leaving the pipeline.
    typedef struct packed {
        logic [1:0]         idx;
        logic               vis;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [23:0]        rgb;
        logic signed [31:0] mean;
    } t_vtx_res;

    function automatic logic [23:0] rgb_of(input logic [7:0] code);
        logic [23:0] c;
        case (code)
            CHR_W:   c = 24'hFFFFFF;
            CHR_G:   c = 24'h00FF00;
            CHR_R:   c = 24'hFF0000;
            CHR_B:   c = 24'h0000FF;
            CHR_M:   c = 24'hFF00FF;
            CHR_Y:   c = 24'hFFFF00;
            CHR_C:   c = 24'h00FFFF;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

endpackage

@@ design/tpp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_in_if / tpp_out_if
// Valid/ready channels that carry one triangle and one projected triangle.
// ----------------------------------------------------------------------------
interface tpp_in_if;
    import tpp_pkg::*;
    logic    valid;
    logic    ready;
    t_tri_in data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tpp_out_if;
    import tpp_pkg::*;
    logic     valid;
    logic     ready;
    t_tri_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/triangle_perspective_projection.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_perspective_projection
// Pinhole projection of one triangle with a yaw rotation about the vertical
// axis, giving screen coordinates, a visibility flag, mean depth and color.
// ----------------------------------------------------------------------------
// The three vertices of a triangle share one rotate-and-divide pipeline with
// two dividers (x and y, one quotient bit per stage) and enter it one per
// cycle while the pipeline is ready; the next triangle is taken as the last
// vertex enters. The output register lets the next triangle in while a result
// waits. The user writes configuration only while idle; the block does not enforce it.
module triangle_perspective_projection (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tpp_in_if.sink                          i_tri,
    tpp_out_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [tpp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tpp_pkg::CFG_DAT_W-1:0]   i_cfg_data
);
    import tpp_pkg::*;

    logic signed [31:0] r_cam_x, r_cam_y, r_cam_z;
    logic signed [15:0] r_cos, r_sin;
    logic [15:0]        r_focal;
    logic [13:0]        r_win_w, r_win_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x <= '0;
            r_cam_y <= '0;
            r_cam_z <= '0;
            r_cos   <= 16'sd16384;
            r_sin   <= '0;
            r_focal <= 16'd256;
            r_win_w <= 14'd640;
            r_win_h <= 14'd480;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CAM_X:   r_cam_x <= i_cfg_data;
                REG_CAM_Y:   r_cam_y <= i_cfg_data;
                REG_CAM_Z:   r_cam_z <= i_cfg_data;
                REG_YAW_COS: r_cos   <= i_cfg_data[15:0];
                REG_YAW_SIN: r_sin   <= i_cfg_data[15:0];
                REG_FOCAL:   r_focal <= i_cfg_data[15:0];
                REG_WIN_W:   r_win_w <= i_cfg_data[13:0];
                REG_WIN_H:   r_win_h <= i_cfg_data[13:0];
                default:     ;
            endcase
        end
    end

    // Triangle holding register, issued one vertex per cycle while the pipeline is ready.
    t_tri_in r_tri;
    logic    r_tv;
    logic [1:0] r_ph;
    logic    w_pin_rdy, w_issue, w_last, w_take;

    assign w_issue     = r_tv && w_pin_rdy;
    assign w_last      = (r_ph == VTX_LAST);
    assign i_tri.ready = !r_tv || (w_last && w_pin_rdy);
    assign w_take      = i_tri.valid && i_tri.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= 1'b0;
            r_ph <= VTX_FIRST;
        end else if (w_take) begin
            r_tv <= 1'b1;
            r_ph <= VTX_FIRST;
        end else if (w_issue) begin
            if (w_last) begin
                r_tv <= 1'b0;
            end else begin
                r_ph <= r_ph + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_tri <= i_tri.data;
        end
    end

    logic signed [31:0] w_sx, w_sy, w_sz;
    logic signed [32:0] w_dz1, w_dz2, w_dz3;
    t_vtx_in            w_vin;

    always_comb begin
        case (r_ph)
            VTX_FIRST: begin
                w_sx = r_tri.v1_x;
                w_sy = r_tri.v1_y;
                w_sz = r_tri.v1_z;
            end
            VTX_SECOND: begin
                w_sx = r_tri.v2_x;
                w_sy = r_tri.v2_y;
                w_sz = r_tri.v2_z;
            end
            default: begin
                w_sx = r_tri.v3_x;
                w_sy = r_tri.v3_y;
                w_sz = r_tri.v3_z;
            end
        endcase
    end

    assign w_dz1 = $signed({r_tri.v1_z[31], r_tri.v1_z}) - $signed({r_cam_z[31], r_cam_z});
    assign w_dz2 = $signed({r_tri.v2_z[31], r_tri.v2_z}) - $signed({r_cam_z[31], r_cam_z});
    assign w_dz3 = $signed({r_tri.v3_z[31], r_tri.v3_z}) - $signed({r_cam_z[31], r_cam_z});

    assign w_vin.idx  = r_ph;
    assign w_vin.vx   = $signed({w_sx[31], w_sx}) - $signed({r_cam_x[31], r_cam_x});
    assign w_vin.vy   = $signed({w_sy[31], w_sy}) - $signed({r_cam_y[31], r_cam_y});
    assign w_vin.vz   = $signed({w_sz[31], w_sz}) - $signed({r_cam_z[31], r_cam_z});
    assign w_vin.dsum = $signed({{2{w_dz1[32]}}, w_dz1}) + $signed({{2{w_dz2[32]}}, w_dz2})
                      + $signed({{2{w_dz3[32]}}, w_dz3});
    assign w_vin.rgb  = rgb_of(r_tri.color_code);

    logic     w_pv, w_prdy, w_pacc;
    t_vtx_res w_pres;

    tpp_vtx_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r_tv),
        .o_in_ready  (w_pin_rdy),
        .i_in        (w_vin),
        .o_out_valid (w_pv),
        .i_out_ready (w_prdy),
        .o_out       (w_pres),
        .i_cos       (r_cos),
        .i_sin       (r_sin),
        .i_focal     (r_focal),
        .i_halfw     ({r_win_w, 15'd0}),
        .i_halfh     ({r_win_h, 15'd0})
    );

    // Vertex collection and output register.
    logic signed [31:0] r_p1x, r_p1y, r_p2x, r_p2y;
    logic               r_vacc;
    logic               r_ov;
    t_tri_out           r_res;
    logic               w_vall;

    assign w_prdy = (w_pres.idx != VTX_LAST) || !r_ov || o_res.ready;
    assign w_pacc = w_pv && w_prdy;
    assign w_vall = r_vacc && w_pres.vis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= (w_pacc && (w_pres.idx == VTX_LAST)) || (r_ov && !o_res.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pacc) begin
            case (w_pres.idx)
                VTX_FIRST: begin
                    r_p1x  <= w_pres.px;
                    r_p1y  <= w_pres.py;
                    r_vacc <= w_pres.vis;
                end
                VTX_SECOND: begin
                    r_p2x  <= w_pres.px;
                    r_p2y  <= w_pres.py;
                    r_vacc <= r_vacc && w_pres.vis;
                end
                default: begin
                    r_res.p1_px      <= w_vall ? r_p1x : '0;
                    r_res.p1_py      <= w_vall ? r_p1y : '0;
                    r_res.p2_px      <= w_vall ? r_p2x : '0;
                    r_res.p2_py      <= w_vall ? r_p2y : '0;
                    r_res.p3_px      <= w_vall ? w_pres.px : '0;
                    r_res.p3_py      <= w_vall ? w_pres.py : '0;
                    r_res.visible    <= w_vall;
                    r_res.rgb_color  <= w_pres.rgb;
                    r_res.mean_depth <= w_pres.mean;
                end
            endcase
        end
    end

    assign o_res.valid = r_ov;
    assign o_res.data  = r_res;

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.data.visible) |->
        (o_res.data.p1_px == 0 && o_res.data.p1_py == 0 && o_res.data.p2_px == 0 &&
         o_res.data.p2_py == 0 && o_res.data.p3_px == 0 && o_res.data.p3_py == 0))
        else $error("hidden triangle carries nonzero pixel coordinates");

    a_take_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (r_tv && r_ph == VTX_FIRST))
        else $error("accepted triangle does not start at its first vertex");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tv |-> (r_ph == VTX_FIRST || r_ph == VTX_SECOND || r_ph == VTX_LAST))
        else $error("vertex phase out of range");

endmodule

@@ design/tpp_vtx_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_vtx_pipe
// Per-vertex pipeline: yaw rotation, focal scaling, a restoring divider with
// one quotient bit per stage for x and y, and the screen offset. Also forms
// the mean depth of the triangle. Stalled stages hold; empty stages fill.
// ----------------------------------------------------------------------------
module tpp_vtx_pipe (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  tpp_pkg::t_vtx_in       i_in,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output tpp_pkg::t_vtx_res      o_out,
    input  logic signed [15:0]     i_cos,
    input  logic signed [15:0]     i_sin,
    input  logic [15:0]            i_focal,
    input  logic [28:0]            i_halfw,
    input  logic [28:0]            i_halfh
);
    import tpp_pkg::*;

    localparam int DIV_N = 41;
    localparam int NST   = DIV_N + 6;
    localparam logic [33:0] RECIP3  = 34'd11453246123;
    localparam logic [16:0] RCP_LO  = RECIP3[16:0];
    localparam logic [16:0] RCP_HI  = RECIP3[33:17];
    localparam logic [40:0] QCAP    = 41'h100_0000_0000;

    typedef struct packed {
        logic [47:0]        d;
        logic               capx;
        logic               capy;
        logic               xneg;
        logic               yneg;
        logic               vis;
        logic [1:0]         idx;
        logic [23:0]        rgb;
        logic signed [31:0] mean;
    } t_side;

    function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
        logic signed [31:0] s;
        if (!v[42] && (v[41:31] != 11'h000)) begin
            s = 32'sh7FFF_FFFF;
        end else if (v[42] && (v[41:31] != 11'h7FF)) begin
            s = 32'sh8000_0000;
        end else begin
            s = v[31:0];
        end
        return s;
    endfunction

    logic [NST-1:0] r_v;
    logic [NST:0]   w_go;

    assign w_go[NST] = i_out_ready;
    genvar g;
    generate
        for (g = 0; g < NST; g++) begin : g_go
            assign w_go[g] = !r_v[g] || w_go[g+1];
        end
    endgenerate

    assign o_in_ready  = w_go[0];
    assign o_out_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_go[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_go[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 1: capture.
    t_vtx_in r1;
    always_ff @(posedge i_clk) begin
        if (w_go[0]) begin
            r1 <= i_in;
        end
    end

    // Stage 2: rotation products and reciprocal products for the mean.
    logic signed [48:0] r2_xc, r2_zs, r2_xs, r2_zc;
    logic signed [46:0] r2_ry;
    logic [50:0]        r2_p0, r2_p1;
    logic               r2_sneg;
    logic [1:0]         r2_idx;
    logic [23:0]        r2_rgb;
    logic [34:0]        w_sabs;

    assign w_sabs = r1.dsum[34] ? 35'(-r1.dsum) : 35'(r1.dsum);

    always_ff @(posedge i_clk) begin
        if (w_go[1]) begin
            r2_xc   <= r1.vx * i_cos;
            r2_zs   <= r1.vz * i_sin;
            r2_xs   <= r1.vx * i_sin;
            r2_zc   <= r1.vz * i_cos;
            r2_ry   <= $signed({r1.vy, 14'd0});
            r2_p0   <= w_sabs[33:0] * RCP_LO;
            r2_p1   <= w_sabs[33:0] * RCP_HI;
            r2_sneg <= r1.dsum[34];
            r2_idx  <= r1.idx;
            r2_rgb  <= r1.rgb;
        end
    end

    // Stage 3: rotated coordinates, magnitudes, depth test, mean depth.
    logic signed [49:0] w_rx, w_rz;
    logic [49:0]        w_xmag;
    logic [46:0]        w_ymag;
    logic [67:0]        w_prod;
    logic [32:0]        w_q3;
    logic signed [31:0] w_mean;
    logic               w_vis;

    assign w_rx   = $signed({r2_xc[48], r2_xc}) - $signed({r2_zs[48], r2_zs});
    assign w_rz   = $signed({r2_xs[48], r2_xs}) + $signed({r2_zc[48], r2_zc});
    assign w_xmag = w_rx[49] ? 50'(-w_rx) : 50'(w_rx);
    assign w_ymag = r2_ry[46] ? 47'(-r2_ry) : 47'(r2_ry);
    assign w_vis  = !w_rz[49] && (w_rz != '0);
    assign w_prod = {r2_p1, 17'd0} + {17'd0, r2_p0};
    assign w_q3   = w_prod[67:35];

    always_comb begin
        if (r2_sneg) begin
            w_mean = (w_q3 > 33'h080000000) ? 32'sh8000_0000 : 32'(-$signed(w_q3));
        end else begin
            w_mean = (w_q3 > 33'h07FFFFFFF) ? 32'sh7FFF_FFFF : w_q3[31:0];
        end
    end

    logic [47:0] r3_xmag, r3_ymag;
    t_side       r3_sd;
    always_ff @(posedge i_clk) begin
        if (w_go[2]) begin
            r3_xmag    <= w_xmag[47:0];
            r3_ymag    <= {1'b0, w_ymag};
            r3_sd.d    <= w_vis ? w_rz[47:0] : 48'd1;
            r3_sd.capx <= 1'b0;
            r3_sd.capy <= 1'b0;
            r3_sd.xneg <= w_rx[49];
            r3_sd.yneg <= r2_ry[46];
            r3_sd.vis  <= w_vis;
            r3_sd.idx  <= r2_idx;
            r3_sd.rgb  <= r2_rgb;
            r3_sd.mean <= w_mean;
        end
    end

    // Stage 4: focal scaling.
    logic [63:0] r4_mx, r4_my;
    t_side       r4_sd;
    always_ff @(posedge i_clk) begin
        if (w_go[3]) begin
            r4_mx <= {16'd0, r3_xmag} * {48'd0, i_focal};
            r4_my <= {16'd0, r3_ymag} * {48'd0, i_focal};
            r4_sd <= r3_sd;
        end
    end

    // Stage 5: overflow test against the quotient cap and divider setup.
    logic [47:0] r_rx [0:DIV_N];
    logic [47:0] r_ry [0:DIV_N];
    logic [40:0] r_nx [0:DIV_N];
    logic [40:0] r_ny [0:DIV_N];
    logic [40:0] r_qx [0:DIV_N];
    logic [40:0] r_qy [0:DIV_N];
    t_side       r_sd [0:DIV_N];
    logic        w_capx, w_capy;
    t_side       w_sd4;

    assign w_capx = {9'd0, r4_mx[63:25]} >= r4_sd.d;
    assign w_capy = {9'd0, r4_my[63:25]} >= r4_sd.d;

    always_comb begin
        w_sd4      = r4_sd;
        w_sd4.capx = w_capx;
        w_sd4.capy = w_capy;
    end

    always_ff @(posedge i_clk) begin
        if (w_go[4]) begin
            r_rx[0]      <= w_capx ? 48'd0 : {9'd0, r4_mx[63:25]};
            r_ry[0]      <= w_capy ? 48'd0 : {9'd0, r4_my[63:25]};
            r_nx[0]      <= {r4_mx[24:0], 16'd0};
            r_ny[0]      <= {r4_my[24:0], 16'd0};
            r_qx[0]      <= '0;
            r_qy[0]      <= '0;
            r_sd[0]      <= w_sd4;
        end
    end

    // Restoring division, one quotient bit per stage.
    generate
        for (g = 0; g < DIV_N; g++) begin : g_div
            logic [48:0] w_tx, w_ty;
            logic        w_gex, w_gey;
            assign w_tx  = {r_rx[g], r_nx[g][40]};
            assign w_ty  = {r_ry[g], r_ny[g][40]};
            assign w_gex = w_tx >= {1'b0, r_sd[g].d};
            assign w_gey = w_ty >= {1'b0, r_sd[g].d};
            always_ff @(posedge i_clk) begin
                if (w_go[5+g]) begin
                    r_rx[g+1] <= w_gex ? 48'(w_tx - {1'b0, r_sd[g].d}) : w_tx[47:0];
                    r_ry[g+1] <= w_gey ? 48'(w_ty - {1'b0, r_sd[g].d}) : w_ty[47:0];
                    r_nx[g+1] <= {r_nx[g][39:0], 1'b0};
                    r_ny[g+1] <= {r_ny[g][39:0], 1'b0};
                    r_qx[g+1] <= {r_qx[g][39:0], w_gex};
                    r_qy[g+1] <= {r_qy[g][39:0], w_gey};
                    r_sd[g+1] <= r_sd[g];
                end
            end
        end
    endgenerate

    // Final stage: sign, half-window offset, saturation.
    logic [40:0]        w_qx, w_qy;
    logic signed [42:0] w_sx, w_sy, w_px, w_py;
    t_side              w_fs;

    assign w_fs = r_sd[DIV_N];
    assign w_qx = w_fs.capx ? QCAP : r_qx[DIV_N];
    assign w_qy = w_fs.capy ? QCAP : r_qy[DIV_N];
    assign w_sx = w_fs.xneg ? -$signed({2'b00, w_qx}) : $signed({2'b00, w_qx});
    assign w_sy = w_fs.yneg ? -$signed({2'b00, w_qy}) : $signed({2'b00, w_qy});
    assign w_px = w_sx + $signed({14'd0, i_halfw});
    assign w_py = $signed({14'd0, i_halfh}) - w_sy;

    always_ff @(posedge i_clk) begin
        if (w_go[NST-1]) begin
            o_out.idx  <= w_fs.idx;
            o_out.vis  <= w_fs.vis;
            o_out.px   <= sat32(w_px);
            o_out.py   <= sat32(w_py);
            o_out.rgb  <= w_fs.rgb;
            o_out.mean <= w_fs.mean;
        end
    end

endmodule

@@ tb/sv/tb_triangle_perspective_projection.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_perspective_projection
// Self-checking bench for the triangle projection block. Triangles come from
// a queue that an initial block fills and go out through a clocked driver.
// A predictor computes each projected triangle when its triangle is taken,
// and a clocked monitor compares every result field by field. The camera,
// yaw, focal length and window size are changed between phases.
// ----------------------------------------------------------------------------
module tb_triangle_perspective_projection;
    import tpp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [40:0] QUOT_CAP = 41'h100_0000_0000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    tpp_in_if  tri_ch ();
    tpp_out_if res_ch ();

    triangle_perspective_projection i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tri      (tri_ch.sink),
        .o_res      (res_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    logic signed [31:0] cam_x, cam_y, cam_z;
    logic signed [15:0] yaw_cos, yaw_sin;
    logic [15:0] focal;
    logic [13:0] win_w, win_h;

    t_tri_in  pending_tris[$];
    t_tri_out expected_proj[$];
    int  mismatches;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;
    int  quiet_cycles;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic logic signed [63:0] scaled_quot(input logic signed [63:0] num,
                                                        input logic signed [63:0] den);
        logic [63:0] mag;
        logic [127:0] prod;
        logic [127:0] q;
        mag  = num[63] ? -num : num;
        prod = ({64'd0, mag} * {112'd0, focal}) << 16;
        q    = prod / {64'd0, den};
        if (q > QUOT_CAP) q = QUOT_CAP;
        return num[63] ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic t_tri_out project_triangle(input t_tri_in t);
        t_tri_out r;
        logic signed [63:0] vx[3], vy[3], vz[3], rx[3], ry[3], rz[3], dsum, half_w, half_h;
        logic signed [31:0] px[3], py[3];
        logic vis;
        vx[0] = t.v1_x; vy[0] = t.v1_y; vz[0] = t.v1_z;
        vx[1] = t.v2_x; vy[1] = t.v2_y; vz[1] = t.v2_z;
        vx[2] = t.v3_x; vy[2] = t.v3_y; vz[2] = t.v3_z;
        vis = 1'b1;
        dsum = 0;
        half_w = {35'd0, win_w, 15'd0};
        half_h = {35'd0, win_h, 15'd0};
        for (int k = 0; k < 3; k++) begin
            vx[k] = vx[k] - cam_x;
            vy[k] = vy[k] - cam_y;
            vz[k] = vz[k] - cam_z;
            rx[k] = vx[k] * yaw_cos - vz[k] * yaw_sin;
            rz[k] = vx[k] * yaw_sin + vz[k] * yaw_cos;
            ry[k] = vy[k] * 64'sd16384;
            dsum += vz[k];
            if (rz[k] <= 0) vis = 1'b0;
        end
        for (int k = 0; k < 3; k++) begin
            px[k] = 0;
            py[k] = 0;
            if (vis) begin
                px[k] = sat32(scaled_quot(rx[k], rz[k]) + half_w);
                py[k] = sat32(half_h - scaled_quot(ry[k], rz[k]));
            end
        end
        r.p1_px = px[0]; r.p1_py = py[0];
        r.p2_px = px[1]; r.p2_py = py[1];
        r.p3_px = px[2]; r.p3_py = py[2];
        r.visible = vis;
        case (t.color_code)
            CHR_W:   r.rgb_color = 24'hFFFFFF;
            CHR_G:   r.rgb_color = 24'h00FF00;
            CHR_R:   r.rgb_color = 24'hFF0000;
            CHR_B:   r.rgb_color = 24'h0000FF;
            CHR_M:   r.rgb_color = 24'hFF00FF;
            CHR_Y:   r.rgb_color = 24'hFFFF00;
            CHR_C:   r.rgb_color = 24'h00FFFF;
            default: r.rgb_color = 24'h000000;
        endcase
        r.mean_depth = sat32(dsum / 3);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h", field, got, want);
        mismatches++;
    endtask

    // Driver: offers the next queued triangle, holding it until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tri_ch.valid <= 1'b0;
        end else if (!tri_ch.valid || tri_ch.ready) begin
            if (pending_tris.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                tri_ch.data  <= pending_tris.pop_front();
                tri_ch.valid <= 1'b1;
            end else begin
                tri_ch.valid <= 1'b0;
            end
        end
    end

    // Predicts at acceptance, before the driver changes the payload.
    always @(posedge i_clk) begin
        if (i_rst_n && tri_ch.valid && tri_ch.ready) begin
            expected_proj.push_back(project_triangle(tri_ch.data));
        end
    end

    // Receiver: random stalls, and a long hold-off when requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            res_ch.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_tri_out want;
        t_tri_out got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            if (expected_proj.size() == 0) begin
                $display("result with no triangle pending");
                mismatches++;
            end else begin
                want = expected_proj.pop_front();
                if (got.p1_px !== want.p1_px) report_mismatch("p1_px", got.p1_px, want.p1_px);
                if (got.p1_py !== want.p1_py) report_mismatch("p1_py", got.p1_py, want.p1_py);
                if (got.p2_px !== want.p2_px) report_mismatch("p2_px", got.p2_px, want.p2_px);
                if (got.p2_py !== want.p2_py) report_mismatch("p2_py", got.p2_py, want.p2_py);
                if (got.p3_px !== want.p3_px) report_mismatch("p3_px", got.p3_px, want.p3_px);
                if (got.p3_py !== want.p3_py) report_mismatch("p3_py", got.p3_py, want.p3_py);
                if (got.visible !== want.visible)
                    report_mismatch("visible", got.visible, want.visible);
                if (got.rgb_color !== want.rgb_color)
                    report_mismatch("rgb_color", got.rgb_color, want.rgb_color);
                if (got.mean_depth !== want.mean_depth)
                    report_mismatch("mean_depth", got.mean_depth, want.mean_depth);
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (tri_ch.valid && tri_ch.ready) || (res_ch.valid && res_ch.ready)
                || hold_cycles > 0) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_CAM_X:   cam_x   = value;
            REG_CAM_Y:   cam_y   = value;
            REG_CAM_Z:   cam_z   = value;
            REG_YAW_COS: yaw_cos = value[15:0];
            REG_YAW_SIN: yaw_sin = value[15:0];
            REG_FOCAL:   focal   = value[15:0];
            REG_WIN_W:   win_w   = value[13:0];
            default:     win_h   = value[13:0];
        endcase
    endtask

    task automatic drain();
        while (pending_tris.size() > 0 || tri_ch.valid || expected_proj.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord(input int spread);
        logic [31:0] v;
        case ($urandom_range(3))
            0:       v = $urandom();
            default: v = $urandom_range(2 * spread) - spread;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] rand_color();
        logic [7:0] letters[7] = '{CHR_W, CHR_G, CHR_R, CHR_B, CHR_M, CHR_Y, CHR_C};
        if ($urandom_range(3) == 0) return 8'($urandom_range(255));
        return letters[$urandom_range(6)];
    endfunction

    // Mostly triangles in front of the camera, so that the divide path is used.
    task automatic queue_random(input int count);
        t_tri_in t;
        int spread;
        for (int n = 0; n < count; n++) begin
            spread = ($urandom_range(1)) ? 32'h0010_0000 : 32'h4000_0000;
            t.v1_x = cam_x + rand_coord(spread);
            t.v1_y = cam_y + rand_coord(spread);
            t.v1_z = cam_z + (($urandom_range(4) == 0) ? rand_coord(spread)
                                                       : $urandom_range(spread) + 1);
            t.v2_x = cam_x + rand_coord(spread);
            t.v2_y = cam_y + rand_coord(spread);
            t.v2_z = cam_z + (($urandom_range(4) == 0) ? rand_coord(spread)
                                                       : $urandom_range(spread) + 1);
            t.v3_x = cam_x + rand_coord(spread);
            t.v3_y = cam_y + rand_coord(spread);
            t.v3_z = cam_z + (($urandom_range(4) == 0) ? rand_coord(spread)
                                                       : $urandom_range(spread) + 1);
            t.color_code = rand_color();
            pending_tris.push_back(t);
        end
    endtask

    task automatic queue_directed();
        t_tri_in t;
        logic [7:0] letters[8] = '{CHR_W, CHR_G, CHR_R, CHR_B, CHR_M, CHR_Y, CHR_C, 8'h00};
        for (int n = 0; n < 8; n++) begin
            t = '{32'sh0001_0000, 32'sh0001_0000, 32'sh000A_0000,
                  -32'sh0001_0000, 32'sh0, 32'sh0005_0000,
                  32'sh0, -32'sh0002_0000, 32'sh0000_0001, letters[n]};
            pending_tris.push_back(t);
        end
        t = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 8'hFF};
        pending_tris.push_back(t);
        // Vertices behind, on and in front of the camera plane.
        t = '{32'sh0, 32'sh0, -32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0001_0000,
              32'sh0, 32'sh0, 32'sh0001_0000, CHR_R};
        pending_tris.push_back(t);
        t = '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0001_0000,
              32'sh0, 32'sh0, 32'sh0001_0000, CHR_B};
        pending_tris.push_back(t);
        t = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'h80};
        pending_tris.push_back(t);
        // Tiny depth with huge offsets saturates the quotient.
        t = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, CHR_W};
        pending_tris.push_back(t);
        t = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
              32'h7FFF_FFFF, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h7FFF_FFFF, 8'h7F};
        pending_tris.push_back(t);
    endtask

    task automatic set_config(input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] cz, input logic [15:0] c,
                              input logic [15:0] s, input logic [15:0] f,
                              input logic [13:0] w, input logic [13:0] h);
        write_reg(REG_CAM_X, cx);
        write_reg(REG_CAM_Y, cy);
        write_reg(REG_CAM_Z, cz);
        write_reg(REG_YAW_COS, {16'd0, c});
        write_reg(REG_YAW_SIN, {16'd0, s});
        write_reg(REG_FOCAL, {16'd0, f});
        write_reg(REG_WIN_W, {18'd0, w});
        write_reg(REG_WIN_H, {18'd0, h});
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        tri_ch.valid   = 1'b0;
        tri_ch.data    = '0;
        res_ch.ready   = 1'b0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        quiet_cycles   = 0;
        cam_x = 0; cam_y = 0; cam_z = 0;
        yaw_cos = 16384; yaw_sin = 0; focal = 256; win_w = 640; win_h = 480;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_directed();
        drain();

        set_config(32'h0002_0000, -32'sh0001_0000, 32'h0000_8000, 16'sd11585,
                   -16'sd11585, 16'd65535, 14'd8192, 14'd8192);
        queue_directed();
        queue_random(200);
        drain();

        set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, -16'sd16384,
                   16'sd16384, 16'd1, 14'd1, 14'd1);
        send_idle_pct = 74;
        queue_random(200);
        drain();

        set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'sd16384,
                   16'sd0, 16'd0, 14'd0, 14'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 74;
        queue_random(200);
        drain();

        set_config(32'h0000_0000, 32'h0000_0000, -32'sh0010_0000, 16'sd15137,
                   16'sd6270, 16'd800, 14'd1920, 14'd1080);
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        queue_random(200);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int p = 0; p < 4; p++) begin
            set_config($urandom(), $urandom(), $urandom(),
                       16'($urandom_range(32768) - 16384),
                       16'($urandom_range(32768) - 16384),
                       16'($urandom_range(65535)), 14'($urandom_range(8192)),
                       14'($urandom_range(8192)));
            if (p == 0) begin
                hold_cycles = 400;
            end
            queue_random(70);
            drain();
        end

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/tpp_pkg.sv
design/tpp_if.sv
design/tpp_vtx_pipe.sv
design/triangle_perspective_projection.sv
tb/sv/tb_triangle_perspective_projection.sv
